// ----- design/bivs_pkg.sv -----
// Package for the beat interval window statistics block.
// Constants, register indexes and the saturation helper; no dependencies.
`default_nettype none

package bivs_pkg;

   localparam int RR_DEPTH_DEF  = 32;
   localparam int QRS_DEPTH_DEF = 32;

   localparam int VAL_W   = 16;          // sample and result width
   localparam int CNT_W   = 9;           // counts up to the largest window (256)
   localparam int S1_W    = 24;          // sum of up to 256 values
   localparam int S2_W    = 40;          // sum of up to 256 squares
   localparam int PROD_W  = 49;          // n * sum of squares
   localparam int DIV_W   = 64;          // shared divider dividend
   localparam int DVS_W   = 32;          // shared divider divisor
   localparam int STEP_W  = 7;           // divider iteration count

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MIN_W      = 6;
   localparam int WIN_OUT_W  = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BEATS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RR_LOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RR_HIGH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QRS_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QRS_HIGH  = 3'd4;

   localparam logic [MIN_W-1:0] MIN_BEATS_RST = 6'd8;
   localparam logic [VAL_W-1:0] RR_LOW_RST    = 16'd800;
   localparam logic [VAL_W-1:0] RR_HIGH_RST   = 16'd48000;
   localparam logic [VAL_W-1:0] QRS_LOW_RST   = 16'd320;
   localparam logic [VAL_W-1:0] QRS_HIGH_RST  = 16'd4800;

   // 60000 ms per minute in Q12.4 squared scaling
   localparam logic [23:0]      RATE_NUM = 24'd15360000;
   localparam logic [VAL_W-1:0] ONE_MS   = 16'd16;

   localparam logic [STEP_W-1:0] STEPS_RATE = 7'd24;
   localparam logic [STEP_W-1:0] STEPS_MEAN = 7'd32;
   localparam logic [STEP_W-1:0] STEPS_VAR  = 7'd32;
   localparam logic [STEP_W-1:0] STEPS_STD  = 7'd64;

   function automatic logic [VAL_W-1:0] sat16(input logic [DIV_W-1:0] v);
      logic [VAL_W-1:0] r;
      r = (v > DIV_W'(16'hFFFF)) ? 16'hFFFF : v[VAL_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/bivs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bivs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- design/beat_interval_window_stats.sv -----
// Top level: RR and QRS sliding windows in RAM, statistics sequencer with a
// shared restoring divider and an integer square root. Uses bivs_pkg, bivs_ram.
//
//  channel  | ports                         | dir | handshake
//  ---------+-------------------------------+-----+-------------------------
//  request  | req_rr_interval, req_qrs_width| in  | req_valid / req_ready
//  response | rsp_* statistics and counts   | out | rsp_valid / rsp_ready
//  csr      | csr_index, csr_wdata          | in  | csr_we, no wait
//
// When statistics run, the shared divider (one quotient bit per cycle) sets the
// time taken per beat. A new beat is taken while the previous result still
// waits on rsp_ready. Reset is synchronous; the window RAMs need no clearing,
// only written entries are read. A stalled response holds the sequencer in its
// last state.
`default_nettype none

module beat_interval_window_stats
   import bivs_pkg::*;
#(
   parameter int RR_DEPTH  = RR_DEPTH_DEF,
   parameter int QRS_DEPTH = QRS_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [VAL_W-1:0]      req_rr_interval,
   input  wire logic [VAL_W-1:0]      req_qrs_width,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_stats_updated,
   output logic [WIN_OUT_W-1:0]       rsp_rr_in_window,
   output logic [VAL_W-1:0]           rsp_rr_mean,
   output logic [VAL_W-1:0]           rsp_rr_std,
   output logic [VAL_W-1:0]           rsp_rr_min,
   output logic [VAL_W-1:0]           rsp_rr_max,
   output logic [VAL_W-1:0]           rsp_rr_variation,
   output logic [VAL_W-1:0]           rsp_rate_mean,
   output logic [VAL_W-1:0]           rsp_rate_std,
   output logic [VAL_W-1:0]           rsp_qrs_mean,
   output logic [VAL_W-1:0]           rsp_qrs_std,
   output logic [WIN_OUT_W-1:0]       rsp_qrs_in_window,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RR_AW  = $clog2(RR_DEPTH);
   localparam int QRS_AW = $clog2(QRS_DEPTH);
   localparam int RR_FW  = $clog2(RR_DEPTH + 1);
   localparam int QRS_FW = $clog2(QRS_DEPTH + 1);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_RR_ADDR = 5'd1;
   localparam logic [4:0] ST_RR_DATA = 5'd2;
   localparam logic [4:0] ST_RR_DIV  = 5'd3;
   localparam logic [4:0] ST_RR_RATE = 5'd4;
   localparam logic [4:0] ST_Q_ADDR  = 5'd5;
   localparam logic [4:0] ST_Q_DATA  = 5'd6;
   localparam logic [4:0] ST_F_MEAN  = 5'd7;
   localparam logic [4:0] ST_F_MEANW = 5'd8;
   localparam logic [4:0] ST_F_MUL   = 5'd9;
   localparam logic [4:0] ST_F_SUB   = 5'd10;
   localparam logic [4:0] ST_F_DIVW  = 5'd11;
   localparam logic [4:0] ST_F_SQRTW = 5'd12;
   localparam logic [4:0] ST_F_NEXT  = 5'd13;
   localparam logic [4:0] ST_VAR_W   = 5'd14;
   localparam logic [4:0] ST_DONE    = 5'd15;

   localparam logic [1:0] SET_RR   = 2'd0;
   localparam logic [1:0] SET_RATE = 2'd1;
   localparam logic [1:0] SET_QRS  = 2'd2;

   // configuration
   logic [MIN_W-1:0] min_beats_ff;
   logic [VAL_W-1:0] rr_low_ff, rr_high_ff, qrs_low_ff, qrs_high_ff;

   // window bookkeeping
   logic [RR_FW-1:0]  rr_fill_ff, rr_fill_in;
   logic [RR_AW-1:0]  rr_oldest_ff, rr_oldest_in;
   logic [QRS_FW-1:0] qrs_fill_ff, qrs_fill_in;
   logic [QRS_AW-1:0] qrs_oldest_ff, qrs_oldest_in;

   // sequencer
   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [1:0]       sel_ff, sel_in;
   logic             stats_ff, stats_in;

   // accumulators and results
   logic [S1_W-1:0]   s1_ff [3];
   logic [S1_W-1:0]   s1_in [3];
   logic [S2_W-1:0]   s2_ff [3];
   logic [S2_W-1:0]   s2_in [3];
   logic [VAL_W-1:0]  mean_ff [3];
   logic [VAL_W-1:0]  mean_in [3];
   logic [VAL_W-1:0]  sd_ff [3];
   logic [VAL_W-1:0]  sd_in [3];
   logic [VAL_W-1:0]  min_ff, min_in, max_ff, max_in;
   logic [VAL_W-1:0]  var_ff, var_in;
   logic [VAL_W-1:0]  rate_ff, rate_in;
   logic [PROD_W-1:0] prod1_ff, prod1_in, prod2_ff, prod2_in;

   // shared divider
   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic [DVS_W-1:0]  div_divisor;
   logic [STEP_W-1:0] div_steps;
   logic [DIV_W-1:0]  div_quo_ff;
   logic [DVS_W:0]    div_rem_ff;
   logic [DVS_W-1:0]  div_den_ff;
   logic [STEP_W-1:0] div_cnt_ff;
   logic [DVS_W:0]    div_shift;

   // square root
   logic             sq_start;
   logic [DIV_W-1:0] sq_x_ff, sq_r_ff, sq_bit_ff, sq_trial;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load;
   logic                 rsp_upd_ff;
   logic [WIN_OUT_W-1:0] rsp_rrw_ff, rsp_qw_ff;
   logic [VAL_W-1:0]     rsp_val_ff [9];

   // RAM ports
   logic              rr_we, qrs_we;
   logic [RR_AW-1:0]  rr_waddr;
   logic [QRS_AW-1:0] qrs_waddr;
   logic [VAL_W-1:0]  rr_rdata, qrs_rdata;

   logic             req_xfer, rr_ok, qrs_ok;
   logic [CNT_W-1:0] rr_n, qrs_n, set_n;
   logic [S1_W-1:0]  set_s1;
   logic [S2_W-1:0]  set_s2;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rr_ok  = (req_rr_interval > rr_low_ff) && (req_rr_interval < rr_high_ff);
   assign qrs_ok = (req_qrs_width > qrs_low_ff) && (req_qrs_width < qrs_high_ff);

   // while filling, oldest stays at zero so the free slot is the fill count
   assign rr_we     = req_xfer && rr_ok;
   assign qrs_we    = req_xfer && qrs_ok;
   assign rr_waddr  = (rr_fill_ff < RR_FW'(RR_DEPTH)) ? rr_fill_ff[RR_AW-1:0] : rr_oldest_ff;
   assign qrs_waddr = (qrs_fill_ff < QRS_FW'(QRS_DEPTH)) ? qrs_fill_ff[QRS_AW-1:0]
                                                          : qrs_oldest_ff;

   bivs_ram #(.WIDTH(VAL_W), .DEPTH(RR_DEPTH)) u_rr_ram (
      .clock (clock),
      .we    (rr_we),
      .waddr (rr_waddr),
      .wdata (req_rr_interval),
      .raddr (idx_ff[RR_AW-1:0]),
      .rdata (rr_rdata)
   );

   bivs_ram #(.WIDTH(VAL_W), .DEPTH(QRS_DEPTH)) u_qrs_ram (
      .clock (clock),
      .we    (qrs_we),
      .waddr (qrs_waddr),
      .wdata (req_qrs_width),
      .raddr (idx_ff[QRS_AW-1:0]),
      .rdata (qrs_rdata)
   );

   assign rr_n  = CNT_W'(rr_fill_ff);
   assign qrs_n = CNT_W'(qrs_fill_ff);

   always_comb begin
      case (sel_ff)
         SET_RR: begin
            set_n  = rr_n;
         end
         SET_RATE: begin
            set_n  = rr_n;
         end
         default: begin
            set_n  = qrs_n;
         end
      endcase
      set_s1 = (sel_ff == SET_QRS) ? s1_ff[2] : (sel_ff == SET_RATE) ? s1_ff[1] : s1_ff[0];
      set_s2 = (sel_ff == SET_QRS) ? s2_ff[2] : (sel_ff == SET_RATE) ? s2_ff[1] : s2_ff[0];
   end

   // window update on each accepted beat whose interval or width lies strictly inside its limits
   always_comb begin
      rr_fill_in    = rr_fill_ff;
      rr_oldest_in  = rr_oldest_ff;
      qrs_fill_in   = qrs_fill_ff;
      qrs_oldest_in = qrs_oldest_ff;
      if (rr_we) begin
         if (rr_fill_ff < RR_FW'(RR_DEPTH)) begin
            rr_fill_in = rr_fill_ff + 1'b1;
         end else begin
            rr_oldest_in = (rr_oldest_ff == RR_AW'(RR_DEPTH - 1)) ? '0 : rr_oldest_ff + 1'b1;
         end
      end
      if (qrs_we) begin
         if (qrs_fill_ff < QRS_FW'(QRS_DEPTH)) begin
            qrs_fill_in = qrs_fill_ff + 1'b1;
         end else begin
            qrs_oldest_in = (qrs_oldest_ff == QRS_AW'(QRS_DEPTH - 1)) ? '0
                                                                    : qrs_oldest_ff + 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      sel_in   = sel_ff;
      stats_in = stats_ff;
      s1_in    = s1_ff;
      s2_in    = s2_ff;
      mean_in  = mean_ff;
      sd_in    = sd_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      var_in   = var_ff;
      rate_in  = rate_ff;
      prod1_in = prod1_ff;
      prod2_in = prod2_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      div_steps    = STEPS_MEAN;
      sq_start     = 1'b0;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               for (int k = 0; k < 3; k++) begin
                  s1_in[k]   = '0;
                  s2_in[k]   = '0;
                  mean_in[k] = '0;
                  sd_in[k]   = '0;
               end
               min_in = '0;
               max_in = '0;
               var_in = '0;
               idx_in = '0;
               sel_in = SET_RR;
               stats_in = CNT_W'(rr_fill_in) >= CNT_W'(min_beats_ff);
               if (CNT_W'(rr_fill_in) < CNT_W'(min_beats_ff)) begin
                  state_in = ST_DONE;
               end else if (rr_fill_in == '0) begin
                  state_in = (qrs_fill_in == '0) ? ST_F_MEAN : ST_Q_ADDR;
               end else begin
                  state_in = ST_RR_ADDR;
               end
            end
         end
         ST_RR_ADDR: begin
            state_in = ST_RR_DATA;
         end
         ST_RR_DATA: begin
            s1_in[0] = s1_ff[0] + S1_W'(rr_rdata);
            s2_in[0] = s2_ff[0] + S2_W'(32'(rr_rdata) * 32'(rr_rdata));
            if (idx_ff == '0 || rr_rdata < min_ff) begin
               min_in = rr_rdata;
            end
            if (idx_ff == '0 || rr_rdata > max_ff) begin
               max_in = rr_rdata;
            end
            if (rr_rdata > ONE_MS) begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(RATE_NUM) + DIV_W'(rr_rdata >> 1);
               div_divisor  = DVS_W'(rr_rdata);
               div_steps    = STEPS_RATE;
               state_in     = ST_RR_DIV;
            end else begin
               rate_in  = '0;
               state_in = ST_RR_RATE;
            end
         end
         ST_RR_DIV: begin
            if (div_cnt_ff == '0) begin
               rate_in  = sat16(div_quo_ff);
               state_in = ST_RR_RATE;
            end
         end
         ST_RR_RATE: begin
            s1_in[1] = s1_ff[1] + S1_W'(rate_ff);
            s2_in[1] = s2_ff[1] + S2_W'(32'(rate_ff) * 32'(rate_ff));
            if (idx_ff + 1'b1 == rr_n) begin
               idx_in   = '0;
               state_in = (qrs_n == '0) ? ST_F_MEAN : ST_Q_ADDR;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_RR_ADDR;
            end
         end
         ST_Q_ADDR: begin
            state_in = ST_Q_DATA;
         end
         ST_Q_DATA: begin
            s1_in[2] = s1_ff[2] + S1_W'(qrs_rdata);
            s2_in[2] = s2_ff[2] + S2_W'(32'(qrs_rdata) * 32'(qrs_rdata));
            if (idx_ff + 1'b1 == qrs_n) begin
               idx_in   = '0;
               state_in = ST_F_MEAN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_Q_ADDR;
            end
         end
         ST_F_MEAN: begin
            if (set_n == '0) begin
               state_in = ST_F_NEXT;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(set_s1) + DIV_W'(set_n >> 1);
               div_divisor  = DVS_W'(set_n);
               div_steps    = STEPS_MEAN;
               state_in     = ST_F_MEANW;
            end
         end
         ST_F_MEANW: begin
            if (div_cnt_ff == '0) begin
               mean_in[sel_ff] = sat16(div_quo_ff);
               state_in = (set_n < CNT_W'(2)) ? ST_F_NEXT : ST_F_MUL;
            end
         end
         ST_F_MUL: begin
            prod1_in = PROD_W'(set_n) * PROD_W'(set_s2);
            prod2_in = PROD_W'(set_s1) * PROD_W'(set_s1);
            state_in = ST_F_SUB;
         end
         ST_F_SUB: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(prod1_ff - prod2_ff);
            div_divisor  = DVS_W'(set_n) * DVS_W'(set_n - 1'b1);
            div_steps    = STEPS_STD;
            state_in     = ST_F_DIVW;
         end
         ST_F_DIVW: begin
            if (div_cnt_ff == '0) begin
               sq_start = 1'b1;
               state_in = ST_F_SQRTW;
            end
         end
         ST_F_SQRTW: begin
            if (sq_bit_ff == '0) begin
               // final remainder is q - r*r: round to nearest
               sd_in[sel_ff] = sat16((sq_x_ff > sq_r_ff) ? sq_r_ff + 1'b1 : sq_r_ff);
               state_in = ST_F_NEXT;
            end
         end
         ST_F_NEXT: begin
            if (sel_ff != SET_QRS) begin
               sel_in   = sel_ff + 1'b1;
               state_in = ST_F_MEAN;
            end else if (mean_ff[0] > ONE_MS) begin
               div_start    = 1'b1;
               div_dividend = DIV_W'({sd_ff[0], 14'd0}) + DIV_W'(mean_ff[0] >> 1);
               div_divisor  = DVS_W'(mean_ff[0]);
               div_steps    = STEPS_VAR;
               state_in     = ST_VAR_W;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_VAR_W: begin
            if (div_cnt_ff == '0) begin
               var_in   = sat16(div_quo_ff);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign div_shift = {div_rem_ff[DVS_W-1:0], div_quo_ff[DIV_W-1]};
   assign sq_trial  = sq_r_ff + sq_bit_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_beats_ff  <= MIN_BEATS_RST;
         rr_low_ff     <= RR_LOW_RST;
         rr_high_ff    <= RR_HIGH_RST;
         qrs_low_ff    <= QRS_LOW_RST;
         qrs_high_ff   <= QRS_HIGH_RST;
         rr_fill_ff    <= '0;
         rr_oldest_ff  <= '0;
         qrs_fill_ff   <= '0;
         qrs_oldest_ff <= '0;
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         div_cnt_ff    <= '0;
         sq_bit_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_BEATS: min_beats_ff <= csr_wdata[MIN_W-1:0];
               CSR_RR_LOW:    rr_low_ff    <= csr_wdata;
               CSR_RR_HIGH:   rr_high_ff   <= csr_wdata;
               CSR_QRS_LOW:   qrs_low_ff   <= csr_wdata;
               CSR_QRS_HIGH:  qrs_high_ff  <= csr_wdata;
               default: ;
            endcase
         end
         rr_fill_ff    <= rr_fill_in;
         rr_oldest_ff  <= rr_oldest_in;
         qrs_fill_ff   <= qrs_fill_in;
         qrs_oldest_ff <= qrs_oldest_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (div_start) begin
            div_cnt_ff <= div_steps;
         end else if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         if (sq_start) begin
            sq_bit_ff <= DIV_W'(1) << (DIV_W - 2);
         end else if (sq_bit_ff != '0) begin
            sq_bit_ff <= sq_bit_ff >> 2;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      sel_ff   <= sel_in;
      stats_ff <= stats_in;
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      mean_ff  <= mean_in;
      sd_ff    <= sd_in;
      min_ff   <= min_in;
      max_ff   <= max_in;
      var_ff   <= var_in;
      rate_ff  <= rate_in;
      prod1_ff <= prod1_in;
      prod2_ff <= prod2_in;

      // restoring divider, one quotient bit per cycle
      if (div_start) begin
         div_quo_ff <= div_dividend << (STEP_W'(DIV_W) - div_steps);
         div_rem_ff <= '0;
         div_den_ff <= div_divisor;
      end else if (div_cnt_ff != '0) begin
         if (div_shift >= {1'b0, div_den_ff}) begin
            div_rem_ff <= div_shift - {1'b0, div_den_ff};
            div_quo_ff <= {div_quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            div_rem_ff <= div_shift;
            div_quo_ff <= {div_quo_ff[DIV_W-2:0], 1'b0};
         end
      end

      // digit-by-digit square root, two radicand bits per cycle
      if (sq_start) begin
         sq_x_ff <= div_quo_ff;
         sq_r_ff <= '0;
      end else if (sq_bit_ff != '0) begin
         if (sq_x_ff >= sq_trial) begin
            sq_x_ff <= sq_x_ff - sq_trial;
            sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
         end else begin
            sq_r_ff <= sq_r_ff >> 1;
         end
      end

      if (rsp_load) begin
         rsp_upd_ff    <= stats_ff;
         rsp_rrw_ff    <= WIN_OUT_W'(rr_n);
         rsp_qw_ff     <= WIN_OUT_W'(qrs_n);
         rsp_val_ff[0] <= mean_ff[0];
         rsp_val_ff[1] <= sd_ff[0];
         rsp_val_ff[2] <= min_ff;
         rsp_val_ff[3] <= max_ff;
         rsp_val_ff[4] <= var_ff;
         rsp_val_ff[5] <= mean_ff[1];
         rsp_val_ff[6] <= sd_ff[1];
         rsp_val_ff[7] <= mean_ff[2];
         rsp_val_ff[8] <= sd_ff[2];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stats_updated = rsp_upd_ff;
   assign rsp_rr_in_window  = rsp_rrw_ff;
   assign rsp_rr_mean       = rsp_val_ff[0];
   assign rsp_rr_std        = rsp_val_ff[1];
   assign rsp_rr_min        = rsp_val_ff[2];
   assign rsp_rr_max        = rsp_val_ff[3];
   assign rsp_rr_variation  = rsp_val_ff[4];
   assign rsp_rate_mean     = rsp_val_ff[5];
   assign rsp_rate_std      = rsp_val_ff[6];
   assign rsp_qrs_mean      = rsp_val_ff[7];
   assign rsp_qrs_std       = rsp_val_ff[8];
   assign rsp_qrs_in_window = rsp_qw_ff;

   a_rr_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rr_fill_ff <= RR_FW'(RR_DEPTH))
      else $error("rr window fill beyond depth");

   a_rr_oldest_full: assert property (@(posedge clock) disable iff (reset)
      rr_oldest_ff != '0 |-> rr_fill_ff == RR_FW'(RR_DEPTH))
      else $error("rr oldest moved before window full");

   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_cnt_ff == '0)
      else $error("divider restarted while busy");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside done state");

endmodule

`default_nettype wire
